// ===== src/sfp_pkg.sv =====
// shared types and constants for the starfield projector
`default_nettype none
package sfp_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_STAR_COUNT   = 3'd0;
    localparam logic [2:0] REG_BASE_SPEED   = 3'd1;
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd2;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd3;
    localparam logic [2:0] REG_RNG_SEED     = 3'd4;

    localparam logic [16:0] DEPTH_ONE = 17'd65536;
    localparam logic [16:0] DEPTH_MIN = 17'd655;

    // back-end sequencer states
    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_READ,
        ST_DEPTH,
        ST_DIVX,
        ST_DIVY,
        ST_CHECK,
        ST_ADDR,
        ST_GRAY,
        ST_EMIT,
        ST_RESPX,
        ST_RESPY
    } t_state;

    // one frame job handed from the front to the back
    typedef struct packed {
        logic [17:0] speed;
    } t_job;

    // one xorshift 13/17/5 step
    function automatic logic [31:0] xorshift(input logic [31:0] v);
        logic [31:0] r;
        r = v ^ (v << 13);
        r = r ^ (r >> 17);
        r = r ^ (r << 5);
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/sfp_front.sv =====
// front end: takes beat items, computes frame speed, queues frame jobs
`default_nettype none
module sfp_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [15:0]         i_beat,
    input  wire  [15:0]         i_base_speed,
    output logic                o_job_valid,
    input  wire                 i_job_ready,
    output sfp_pkg::t_job       o_job
);
    import sfp_pkg::*;

    // two-entry queue of frame jobs
    t_job       r_q [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic [33:0] w_prod;
    logic        w_push, w_pop;

    assign w_prod = 34'({i_base_speed, 16'd0}) + 34'({i_base_speed, 1'b0}) * 34'(i_beat);
    assign o_ready = (r_cnt != 2'd2);
    assign w_push = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop = o_job_valid && i_job_ready;
    assign o_job = r_q[r_rp];

    // pointer and count update
    always_comb begin
        n_wp = r_wp ^ w_push;
        n_rp = r_rp ^ w_pop;
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp].speed <= w_prod[33:16];
        end
    end
endmodule
`default_nettype wire

// ===== src/sfp_div.sv =====
// restoring divider, one quotient bit per cycle, unsigned
`default_nettype none
module sfp_div (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_start,
    input  wire  [29:0]  i_num,
    input  wire  [17:0]  i_den,
    output logic         o_done,
    output logic [29:0]  o_quot
);
    import sfp_pkg::*;

    logic [29:0] r_q;
    logic [18:0] r_rem;
    logic [17:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [18:0] w_sh;
    logic [18:0] w_sub;

    assign w_sh  = {r_rem[17:0], r_q[29]};
    assign w_sub = w_sh - {1'b0, r_den};
    assign o_quot = r_q;

    // shift-subtract loop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 5'd29;
            end else if (r_busy) begin
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_sub[18]) begin
                r_rem <= w_sub;
                r_q <= {r_q[28:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q <= {r_q[28:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/sfp_back.sv =====
// back end: fills the star table, walks it per frame job, projects and emits results
`default_nettype none
module sfp_back #(
    parameter int STAR_SLOTS = 64,
    parameter int COORD_BITS = 11
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_job_valid,
    output logic                o_job_ready,
    input  sfp_pkg::t_job       i_job,
    input  wire                 i_refill,
    input  wire                 i_seed_load,
    input  wire  [31:0]         i_seed,
    input  wire  [6:0]          i_star_count,
    input  wire  [11:0]         i_width,
    input  wire  [11:0]         i_height,
    output logic                o_idle,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [5:0]          o_index,
    output logic [10:0]         o_x,
    output logic [10:0]         o_y,
    output logic [21:0]         o_addr,
    output logic [7:0]          o_gray,
    output logic                o_write,
    output logic                o_last
);
    import sfp_pkg::*;

    localparam int IW = (STAR_SLOTS > 1) ? $clog2(STAR_SLOTS) : 1;
    localparam logic [12:0] LIM = 13'(1 << COORD_BITS);

    // star tables
    logic [15:0] r_xs [STAR_SLOTS];
    logic [15:0] r_ys [STAR_SLOTS];
    logic [16:0] r_zs [STAR_SLOTS];

    t_state r_st, n_st;
    logic [31:0] r_gen;
    logic [6:0]  r_i;
    logic [6:0]  r_n;
    logic [1:0]  r_fph;
    logic [17:0] r_speed;
    logic [15:0] r_x, r_y;
    logic signed [18:0] r_z;
    logic [12:0] r_w, r_h;
    logic signed [30:0] r_colq, r_rowq;
    logic        r_neg;
    logic        r_show;
    logic [21:0] r_addr;
    logic [24:0] r_gp;
    logic        r_ov;
    logic [5:0]  r_oi;
    logic [10:0] r_ox, r_oy;
    logic [21:0] r_oa;
    logic [7:0]  r_og;
    logic        r_ow, r_ol;

    logic        w_dstart, w_ddone;
    logic [29:0] w_num, w_quot;
    logic signed [30:0] w_snum;
    logic [17:0] w_den;
    logic signed [15:0] w_coord;
    logic [12:0] w_dim;
    logic [31:0] w_gnext;
    logic [IW-1:0] w_ix;
    logic signed [30:0] w_sq;
    logic [6:0]  w_nact;

    assign w_gnext = xorshift(r_gen);
    assign w_ix = r_i[IW-1:0];
    assign w_nact = (i_star_count > 7'(STAR_SLOTS)) ? 7'(STAR_SLOTS) : i_star_count;

    // divider operands: dim*(z+2c), magnitude divided by 2z
    // column operands when started from the depth step, row operands after
    assign w_coord = (r_st == ST_DEPTH) ? $signed(r_x) : $signed(r_y);
    assign w_dim   = (r_st == ST_DEPTH) ? r_w : r_h;
    assign w_snum  = 31'($signed({1'b0, w_dim})) * (31'(r_z) + 31'(w_coord) * 31'sd2);
    assign w_num   = w_snum[30] ? 30'(-w_snum) : w_snum[29:0];
    assign w_den   = 18'(r_z) << 1;
    assign w_sq    = r_neg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});

    sfp_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_dstart),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_done (w_ddone),
        .o_quot (w_quot)
    );

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_FILL:  if (r_i == r_n && !i_refill) n_st = ST_IDLE;
            ST_IDLE:  if (i_refill) n_st = ST_FILL;
                      else if (i_job_valid) n_st = (w_nact == 7'd0) ? ST_IDLE : ST_READ;
            ST_READ:  n_st = ST_DEPTH;
            ST_DEPTH: n_st = (r_z > $signed({1'b0, DEPTH_MIN})) ? ST_DIVX : ST_RESPX;
            ST_DIVX:  if (w_ddone) n_st = ST_DIVY;
            ST_DIVY:  if (w_ddone) n_st = ST_CHECK;
            ST_CHECK: n_st = ST_ADDR;
            ST_ADDR:  n_st = r_show ? ST_GRAY : ST_RESPX;
            ST_GRAY:  n_st = ST_EMIT;
            ST_RESPX: n_st = ST_RESPY;
            ST_RESPY: n_st = ST_EMIT;
            ST_EMIT:  if (!r_ov) n_st = (r_i + 7'd1 == r_n) ? ST_IDLE : ST_READ;
            default:  n_st = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_job_ready = (r_st == ST_IDLE) && !i_refill;
        w_dstart = 1'b0;
        if ((r_st == ST_DEPTH) && (r_z > $signed({1'b0, DEPTH_MIN}))) w_dstart = 1'b1;
        if ((r_st == ST_DIVX) && w_ddone) w_dstart = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_FILL;
            r_gen <= 32'd1;
            r_i <= '0;
            r_n <= 7'(STAR_SLOTS);
            r_fph <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_ready) r_ov <= 1'b0;
            case (r_st)
                ST_FILL: begin
                    if (r_i != r_n) begin
                        r_gen <= w_gnext;
                        r_fph <= (r_fph == 2'd2) ? 2'd0 : r_fph + 2'd1;
                        if (r_fph == 2'd2) r_i <= r_i + 7'd1;
                    end
                end
                ST_IDLE: begin
                    r_i <= '0;
                    r_n <= w_nact;
                end
                ST_RESPX, ST_RESPY: r_gen <= w_gnext;
                ST_EMIT: if (!r_ov) begin
                    r_ov <= 1'b1;
                    r_i <= r_i + 7'd1;
                end
                default: ;
            endcase
            // a refill restarts the table fill
            if (i_refill) begin
                r_st <= ST_FILL;
                r_i <= '0;
                r_fph <= '0;
                r_n <= w_nact;
                if (i_seed_load) r_gen <= i_seed;
            end
        end
    end

    // datapath and table writes
    always_ff @(posedge i_clk) begin
        if (r_st == ST_FILL && r_i != r_n) begin
            case (r_fph)
                2'd0:    r_xs[w_ix] <= w_gnext[15:0] ^ 16'h8000;
                2'd1:    r_ys[w_ix] <= w_gnext[15:0] ^ 16'h8000;
                default: r_zs[w_ix] <= {1'b0, w_gnext[15:0]};
            endcase
        end
        if (o_job_ready && i_job_valid) begin
            r_speed <= i_job.speed;
            r_w <= ({1'b0, i_width} > LIM) ? LIM : {1'b0, i_width};
            r_h <= ({1'b0, i_height} > LIM) ? LIM : {1'b0, i_height};
        end
        // sign of the numerator being divided
        if (w_dstart) r_neg <= w_snum[30];
        case (r_st)
            ST_READ: begin
                r_x <= r_xs[w_ix];
                r_y <= r_ys[w_ix];
            end
            ST_DEPTH: ;
            ST_DIVX: if (w_ddone) r_colq <= w_sq;
            ST_DIVY: if (w_ddone) r_rowq <= w_sq;
            ST_CHECK: r_show <= !r_colq[30] && (r_colq < $signed({18'd0, r_w}))
                             && !r_rowq[30] && (r_rowq < $signed({18'd0, r_h}));
            ST_ADDR: r_addr <= 22'(r_rowq[12:0] * r_w) + 22'(r_colq[12:0]);
            ST_GRAY: begin
                r_gp <= 25'(DEPTH_ONE - r_z[16:0]) * 25'd255;
                r_zs[w_ix] <= r_z[16:0];
            end
            ST_RESPX: r_xs[w_ix] <= w_gnext[15:0] ^ 16'h8000;
            ST_RESPY: begin
                r_ys[w_ix] <= w_gnext[15:0] ^ 16'h8000;
                r_zs[w_ix] <= DEPTH_ONE;
                r_show <= 1'b0;
            end
            default: ;
        endcase
        // depth after the speed step
        if (r_st == ST_READ) r_z <= $signed({1'b0, r_zs[w_ix]}) - $signed({1'b0, r_speed});
        // output register
        if (r_st == ST_EMIT && !r_ov) begin
            r_oi <= r_i[5:0];
            r_ow <= r_show;
            r_ol <= (r_i + 7'd1 == r_n);
            r_ox <= r_show ? 11'(r_colq) : 11'd0;
            r_oy <= r_show ? 11'(r_rowq) : 11'd0;
            r_oa <= r_show ? r_addr : 22'd0;
            r_og <= r_show ? r_gp[23:16] : 8'd0;
        end
    end

    assign o_idle = (r_st == ST_IDLE);
    assign o_valid = r_ov;
    assign o_index = r_oi;
    assign o_x = r_ox;
    assign o_y = r_oy;
    assign o_addr = r_oa;
    assign o_gray = r_og;
    assign o_write = r_ow;
    assign o_last = r_ol;
endmodule
`default_nettype wire

// ===== src/starfield_projector.sv =====
// top level of the starfield projector
// Each input item is one frame tick carrying a beat level; the block then walks the
// active stars in index order and returns one result item per star, the last one with
// tlast set. For each star whose depth stays above DEPTH_MIN the back end runs two
// 30-step serial divides (column and row). After reset, and after each write of
// star_count or rng_seed, the table is refilled at three generator steps per star
// before the back end takes the next frame.
// The configuration port is ready only while no frame is queued or being walked.
`default_nettype none
module starfield_projector #(
    parameter int STAR_SLOTS = 64,
    parameter int COORD_BITS = 11
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [15:0]  s_axis_tdata,     // beat_decay
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [63:0]  m_axis_tdata,     // star_index, pixel_x, pixel_y, pixel_address,
                                           // gray_level, zero pad
    output logic         m_axis_tuser,     // write_pixel
    output logic         m_axis_tlast,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [2:0]   i_cfg_index,
    input  wire  [31:0]  i_cfg_data
);
    import sfp_pkg::*;

    logic [6:0]  r_count;
    logic [15:0] r_speed;
    logic [11:0] r_width, r_height;
    logic        w_wr, w_refill, w_seed;
    logic        w_jv, w_jr;
    logic        w_idle;
    t_job        w_job;
    logic [5:0]  w_idx;
    logic [10:0] w_x, w_y;
    logic [21:0] w_a;
    logic [7:0]  w_g;

    assign o_cfg_ready = w_idle && !w_jv;
    assign w_wr = i_cfg_valid && o_cfg_ready;
    assign w_seed = w_wr && (i_cfg_index == REG_RNG_SEED);
    assign w_refill = w_seed || (w_wr && (i_cfg_index == REG_STAR_COUNT));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 7'd64;
            r_speed <= 16'd655;
            r_width <= 12'd320;
            r_height <= 12'd240;
        end else if (w_wr) begin
            case (i_cfg_index)
                REG_STAR_COUNT:   r_count <= i_cfg_data[6:0];
                REG_BASE_SPEED:   r_speed <= i_cfg_data[15:0];
                REG_FRAME_WIDTH:  r_width <= i_cfg_data[11:0];
                REG_FRAME_HEIGHT: r_height <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    sfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_beat      (s_axis_tdata),
        .i_base_speed(r_speed),
        .o_job_valid (w_jv),
        .i_job_ready (w_jr),
        .o_job       (w_job)
    );

    sfp_back #(.STAR_SLOTS(STAR_SLOTS), .COORD_BITS(COORD_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_jv),
        .o_job_ready (w_jr),
        .i_job       (w_job),
        .i_refill    (w_refill),
        .i_seed_load (w_seed),
        .i_seed      (i_cfg_data),
        .i_star_count(w_refill && !w_seed ? i_cfg_data[6:0] : r_count),
        .i_width     (r_width),
        .i_height    (r_height),
        .o_idle      (w_idle),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_index     (w_idx),
        .o_x         (w_x),
        .o_y         (w_y),
        .o_addr      (w_a),
        .o_gray      (w_g),
        .o_write     (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, w_g, w_a, w_y, w_x, w_idx};
endmodule
`default_nettype wire

// ===== sim/tb_starfield_projector.sv =====
// testbench for the starfield projector: frame items in, checked star results out
`default_nettype none
module tb_starfield_projector;
    import sfp_pkg::*;

    localparam int SLOTS    = 64;
    localparam int DIM_LIMIT = 2048;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [63:0] m_axis_tdata;
    wire         m_axis_tuser;
    wire         m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    wire         o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    starfield_projector dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    typedef struct {
        logic [5:0]  star;
        logic [10:0] col;
        logic [10:0] row;
        logic [21:0] addr;
        logic [7:0]  gray;
        logic        written;
        logic        last;
    } t_pixel;

    t_pixel pixel_q[$];
    int     errors = 0;
    int     max_gap = 14;

    // shadow copy of registers and star table
    logic [6:0]  star_count;
    logic [15:0] base_speed;
    logic [11:0] frame_w;
    logic [11:0] frame_h;
    logic [31:0] gen_word;
    longint      star_x[SLOTS];
    longint      star_y[SLOTS];
    longint      star_z[SLOTS];

    function automatic longint next_word16();
        logic [31:0] r;
        r = gen_word;
        r = r ^ (r << 13);
        r = r ^ (r >> 17);
        r = r ^ (r << 5);
        gen_word = r;
        return longint'(r[15:0]);
    endfunction

    function automatic int active_stars();
        return (star_count > SLOTS) ? SLOTS : int'(star_count);
    endfunction

    function automatic void refill_stars();
        for (int i = 0; i < active_stars(); i++) begin
            star_x[i] = next_word16() - 32768;
            star_y[i] = next_word16() - 32768;
            star_z[i] = next_word16();
        end
    endfunction

    function automatic longint clamp_dim(logic [11:0] d);
        return (d > DIM_LIMIT) ? longint'(DIM_LIMIT) : longint'(d);
    endfunction

    // advance the star table by one frame and queue the pixel results
    function automatic void project_frame(logic [15:0] beat);
        longint speed, w, h, z, col, row;
        int     n;
        bit     shown;
        t_pixel p;
        speed = (longint'(base_speed) * (65536 + 2 * longint'(beat))) >>> 16;
        w = clamp_dim(frame_w);
        h = clamp_dim(frame_h);
        n = active_stars();
        for (int i = 0; i < n; i++) begin
            z = star_z[i] - speed;
            shown = 0;
            col = 0;
            row = 0;
            if (z > 655) begin
                col = (w * (z + 2 * star_x[i])) / (2 * z);
                row = (h * (z + 2 * star_y[i])) / (2 * z);
                shown = col >= 0 && col < w && row >= 0 && row < h;
            end
            p.star = i[5:0];
            p.written = shown;
            p.last = (i + 1 == n);
            if (shown) begin
                star_z[i] = z;
                p.col = col[10:0];
                p.row = row[10:0];
                p.addr = 22'(row * w + col);
                p.gray = 8'(((65536 - z) * 255) >>> 16);
            end else begin
                star_x[i] = next_word16() - 32768;
                star_y[i] = next_word16() - 32768;
                star_z[i] = 65536;
                p.col = '0;
                p.row = '0;
                p.addr = '0;
                p.gray = '0;
            end
            pixel_q.push_back(p);
        end
    endfunction

    // result side: random stalls, compare each accepted item
    initial begin : result_checker
        int     k;
        logic [63:0] d;
        t_pixel e;
        forever begin
            k = $urandom_range(0, max_gap);
            if (k > 0) begin
                m_axis_tready <= 1'b0;
                repeat (k) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
            d = m_axis_tdata;
            if (pixel_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected item tdata=%h", $time, d);
            end else begin
                e = pixel_q.pop_front();
                if (d[5:0] !== e.star || d[16:6] !== e.col || d[27:17] !== e.row ||
                    d[49:28] !== e.addr || d[57:50] !== e.gray ||
                    m_axis_tuser !== e.written || m_axis_tlast !== e.last) begin
                    errors++;
                    $display("%0t: mismatch expected star=%0d x=%0d y=%0d addr=%0d gray=%0d wr=%0b last=%0b",
                             $time, e.star, e.col, e.row, e.addr, e.gray, e.written, e.last);
                    $display("%0t:          actual   star=%0d x=%0d y=%0d addr=%0d gray=%0d wr=%0b last=%0b",
                             $time, d[5:0], d[16:6], d[27:17], d[49:28], d[57:50],
                             m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    // send one frame tick, predicting at acceptance
    task automatic send_beat(input logic [15:0] beat);
        int k;
        k = $urandom_range(0, max_gap);
        if (k > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (k) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        project_frame(beat);
    endtask

    // wait for outstanding results, then let the block settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_STAR_COUNT: begin
                star_count = value[6:0];
                refill_stars();
            end
            REG_BASE_SPEED:   base_speed = value[15:0];
            REG_FRAME_WIDTH:  frame_w = value[11:0];
            REG_FRAME_HEIGHT: frame_h = value[11:0];
            REG_RNG_SEED: begin
                gen_word = value;
                refill_stars();
            end
            default: ;
        endcase
    endtask

    // reset settings: beat extremes and every third beat bit
    task automatic test_beat_levels();
        send_beat(16'h0000);
        send_beat(16'hFFFF);
        for (int b = 0; b < 16; b += 3) send_beat(16'h1 << b);
        wait_idle();
    endtask

    // register extremes and the special cases
    task automatic test_register_extremes();
        write_reg(REG_STAR_COUNT, 32'd1);
        write_reg(REG_BASE_SPEED, 32'd0);
        send_beat(16'hFFFF);
        wait_idle();
        write_reg(REG_STAR_COUNT, 32'd127);
        write_reg(REG_FRAME_WIDTH, 32'd4095);
        write_reg(REG_FRAME_HEIGHT, 32'd2048);
        write_reg(REG_BASE_SPEED, 32'd200);
        send_beat(16'h0000);
        send_beat(16'h8000);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 32'd1);
        write_reg(REG_FRAME_HEIGHT, 32'd0);
        send_beat(16'h0001);
        wait_idle();
        write_reg(REG_RNG_SEED, 32'd0);
        write_reg(REG_FRAME_WIDTH, 32'd320);
        write_reg(REG_FRAME_HEIGHT, 32'd240);
        send_beat(16'h0000);
        wait_idle();
        write_reg(REG_RNG_SEED, 32'hFFFF_FFFF);
        write_reg(REG_BASE_SPEED, 32'hFFFF);
        send_beat(16'h0000);
        wait_idle();
        // zero stars: frame causes no result
        write_reg(REG_STAR_COUNT, 32'd0);
        send_beat(16'h1234);
        wait_idle();
        write_reg(REG_STAR_COUNT, 32'd64);
        write_reg(REG_BASE_SPEED, 32'd655);
        send_beat(16'h0100);
        wait_idle();
    endtask

    // random settings per phase, random beats within
    task automatic test_random_frames();
        for (int ph = 0; ph < 29; ph++) begin
            max_gap = (ph % 4 == 3) ? 0 : 14;
            write_reg(REG_RNG_SEED, $urandom());
            write_reg(REG_STAR_COUNT, (ph % 9 == 4) ? $urandom_range(64, 127)
                                                    : $urandom_range(1, 12));
            write_reg(REG_BASE_SPEED, (ph % 3 == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 2000));
            write_reg(REG_FRAME_WIDTH, (ph % 5 == 2) ? $urandom_range(0, 4095)
                                                     : $urandom_range(1, 640));
            write_reg(REG_FRAME_HEIGHT, (ph % 5 == 1) ? $urandom_range(0, 4095)
                                                      : $urandom_range(1, 480));
            for (int i = 0; i < 10; i++)
                send_beat((i % 2) ? $urandom_range(0, 65535) : $urandom_range(0, 4096));
            wait_idle();
        end
    endtask

    initial begin : main_sequence
        star_count = 7'd64;
        base_speed = 16'd655;
        frame_w = 12'd320;
        frame_h = 12'd240;
        gen_word = 32'd1;
        refill_stars();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_beat_levels();
        test_register_extremes();
        test_random_frames();
        if (errors == 0)
            $display("starfield_projector verification clean");
        else
            $display("starfield_projector verification failed");
        $finish;
    end

    initial begin : watchdog
        #60000000;
        $display("starfield_projector verification failed");
        $finish;
    end

endmodule
`default_nettype wire
